// ----- hw/rtl/bss_pkg.sv -----
`timescale 1ns / 1ps

package bss_pkg;

	localparam int OP_W     = 2;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 7;
	localparam int CAP_W    = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_DUMP   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED   = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_POPPED   = 3'd3,
		ST_FOUND    = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POP  = 5'b00010,
		S_RD   = 5'b00100,
		S_EV   = 5'b01000,
		S_FIN  = 5'b10000
	} fsm_t;

endpackage

// ----- hw/rtl/bss_cmd_if.sv -----
`timescale 1ns / 1ps

interface bss_cmd_if;
	logic                                valid;
	logic                                ready;
	logic        [bss_pkg::OP_W-1:0]     opcode;
	logic signed [bss_pkg::WORD_W-1:0]   push_value;
	logic signed [bss_pkg::WORD_W-1:0]   search_key;

	modport source (output valid, output opcode, output push_value, output search_key,
		input ready);
	modport sink (input valid, input opcode, input push_value, input search_key,
		output ready);
endinterface

// ----- hw/rtl/bss_res_if.sv -----
`timescale 1ns / 1ps

interface bss_res_if;
	logic                                valid;
	logic                                ready;
	logic        [bss_pkg::STATUS_W-1:0] status;
	logic signed [bss_pkg::WORD_W-1:0]   data;
	logic        [bss_pkg::POS_W-1:0]    position;
	logic                                occupied;
	logic                                last;

	modport source (output valid, output status, output data, output position,
		output occupied, output last, input ready);
	modport sink (input valid, input status, input data, input position,
		input occupied, input last, output ready);
endinterface

// ----- hw/rtl/bounded_stack_with_search_unit.sv -----
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words in a single-port-read, single-port-write
// synchronous memory of DEPTH entries. Push, a full push, and pop or search on an empty
// stack may follow each other every cycle while the result register is free. A pop
// that returns a word reads the top slot on acceptance and sends it from S_POP. Search
// and dump walk the memory through its one read port, each slot read in S_RD and
// compared in S_EV, over count slots for search and the effective capacity for dump;
// search closes in S_FIN. Input is held off during the walk and while the result
// register is full and not being taken. Results leave through a result register, so
// the next word is taken in the same cycle as a waiting result. Capacity is clamped
// to 1..DEPTH and must be written by the user only while idle; the block does not
// enforce it. The memory needs no clearing after reset: only live slots are returned.

module bounded_stack_with_search_unit #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bss_cmd_if.sink                       cmd,
	bss_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [bss_pkg::CAP_W-1:0]     cfg_wdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = bss_pkg::POS_W;
	localparam int WW = bss_pkg::WORD_W;

	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;

	bss_pkg::fsm_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] bound_q, bound_d;
	logic          dump_q, dump_d;
	logic          pend_q, pend_d;
	logic [PW-1:0] pend_pos_q, pend_pos_d;
	logic [WW-1:0] key_q, key_d;
	logic [bss_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0] cap_eff;

	logic              res_valid_q;
	bss_pkg::status_t  res_status_q;
	logic [WW-1:0]     res_data_q;
	logic [PW-1:0]     res_pos_q;
	logic              res_occ_q;
	logic              res_last_q;

	logic              out_free;
	logic              out_load;
	bss_pkg::status_t  out_status;
	logic [WW-1:0]     out_data;
	logic [PW-1:0]     out_pos;
	logic              out_occ;
	logic              out_last;

	logic              cmd_fire;
	logic              last_idx;
	logic              live;
	logic              match;
	logic [PW-1:0]     idx_pos;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_q > bss_pkg::CAP_W'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	assign out_free  = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == bss_pkg::S_IDLE) && out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign last_idx = (idx_q + CW'(1)) == bound_q;
	assign live     = idx_q < count_q;
	assign match    = rd_q == key_q;
	assign idx_pos  = PW'(idx_q) + PW'(1);

	always_comb begin
		unique case (state_q)
			bss_pkg::S_IDLE: rd_addr = AW'(count_q - CW'(1));
			bss_pkg::S_POP:  rd_addr = count_q[AW-1:0];
			default:         rd_addr = idx_q[AW-1:0];
		endcase
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		bound_d    = bound_q;
		dump_d     = dump_q;
		pend_d     = pend_q;
		pend_pos_d = pend_pos_q;
		key_d      = key_q;
		mem_we     = 1'b0;
		out_load   = 1'b0;
		out_status = bss_pkg::ST_PUSHED;
		out_data   = '0;
		out_pos    = '0;
		out_occ    = 1'b0;
		out_last   = 1'b1;
		unique case (state_q)
			bss_pkg::S_IDLE: begin
				if (cmd_fire) begin
					unique case (bss_pkg::opcode_t'(cmd.opcode))
						bss_pkg::OP_PUSH: begin
							out_load = 1'b1;
							if (count_q >= cap_eff) begin
								out_status = bss_pkg::ST_FULL;
							end else begin
								mem_we     = 1'b1;
								count_d    = count_q + CW'(1);
								out_status = bss_pkg::ST_PUSHED;
							end
						end
						bss_pkg::OP_POP: begin
							if (count_q == '0) begin
								out_load   = 1'b1;
								out_status = bss_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
								state_d = bss_pkg::S_POP;
							end
						end
						bss_pkg::OP_SEARCH: begin
							if (count_q == '0) begin
								out_load   = 1'b1;
								out_status = bss_pkg::ST_EMPTY;
							end else begin
								key_d   = cmd.search_key;
								idx_d   = '0;
								bound_d = count_q;
								dump_d  = 1'b0;
								pend_d  = 1'b0;
								state_d = bss_pkg::S_RD;
							end
						end
						bss_pkg::OP_DUMP: begin
							idx_d   = '0;
							bound_d = cap_eff;
							dump_d  = 1'b1;
							pend_d  = 1'b0;
							state_d = bss_pkg::S_RD;
						end
					endcase
				end
			end
			bss_pkg::S_POP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = bss_pkg::ST_POPPED;
					out_data   = rd_q;
					state_d    = bss_pkg::S_IDLE;
				end
			end
			bss_pkg::S_RD: begin
				state_d = bss_pkg::S_EV;
			end
			bss_pkg::S_EV: begin
				if (dump_q) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_status = bss_pkg::ST_FOUND;
						out_data   = live ? rd_q : '0;
						out_pos    = idx_pos;
						out_occ    = live;
						out_last   = last_idx;
						if (last_idx) begin
							state_d = bss_pkg::S_IDLE;
						end else begin
							idx_d   = idx_q + CW'(1);
							state_d = bss_pkg::S_RD;
						end
					end
				end else if (!(match && pend_q) || out_free) begin
					// an earlier match goes out once a later one shows up; the last match goes out from S_FIN
					if (match && pend_q) begin
						out_load   = 1'b1;
						out_status = bss_pkg::ST_FOUND;
						out_pos    = pend_pos_q;
						out_last   = 1'b0;
					end
					if (match) begin
						pend_d     = 1'b1;
						pend_pos_d = idx_pos;
					end
					if (last_idx) begin
						state_d = bss_pkg::S_FIN;
					end else begin
						idx_d   = idx_q + CW'(1);
						state_d = bss_pkg::S_RD;
					end
				end
			end
			bss_pkg::S_FIN: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = pend_q ? bss_pkg::ST_FOUND : bss_pkg::ST_NOTFOUND;
					out_pos    = pend_q ? pend_pos_q : '0;
					state_d    = bss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bss_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= cmd.push_value;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bss_pkg::S_IDLE;
			count_q     <= '0;
			cap_q       <= bss_pkg::CAP_RESET;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		bound_q    <= bound_d;
		dump_q     <= dump_d;
		pend_pos_q <= pend_pos_d;
		key_q      <= key_d;
		if (out_load) begin
			res_status_q <= out_status;
			res_data_q   <= out_data;
			res_pos_q    <= out_pos;
			res_occ_q    <= out_occ;
			res_last_q   <= out_last;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.status   = res_status_q;
	assign res.data     = res_data_q;
	assign res.position = res_pos_q;
	assign res.occupied = res_occ_q;
	assign res.last     = res_last_q;

endmodule

// ----- hw/rtl/bss_checker.sv -----
`timescale 1ns / 1ps

module bss_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [bss_pkg::STATUS_W-1:0]    res_status,
	input logic [bss_pkg::WORD_W-1:0]      res_data,
	input logic [bss_pkg::POS_W-1:0]       res_position,
	input logic                            res_occupied,
	input logic                            res_last
);

	// stalled word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_data)
			&& $stable(res_position) && $stable(res_occupied) && $stable(res_last))
		else $error("result word changed while stalled");

	// only found or dump words can be followed by more words of the same item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != bss_pkg::ST_FOUND |-> res_last)
		else $error("single-word result without last");

	a_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != bss_pkg::ST_FOUND |-> res_position == '0 && !res_occupied)
		else $error("position or occupied set outside found or dump");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != bss_pkg::ST_POPPED && !res_occupied |-> res_data == '0)
		else $error("data set on a word that carries none");

	a_occ_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_occupied |-> res_status == bss_pkg::ST_FOUND && res_position != '0)
		else $error("occupied slot without found status or position");

endmodule

bind bounded_stack_with_search_unit bss_checker u_bss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_status   (res.status),
	.res_data     (res.data),
	.res_position (res.position),
	.res_occupied (res.occupied),
	.res_last     (res.last)
);

// ----- sim/bounded_stack_with_search_unit_tb.sv -----
`timescale 1ns / 1ps

module bounded_stack_with_search_unit_tb;

	localparam int DEPTH       = 64;
	localparam int RAND_WORDS  = 450;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_WAIT  = 200;

	typedef struct packed {
		bss_pkg::status_t   status;
		logic signed [31:0] data;
		logic [6:0]         position;
		logic               occupied;
		logic               last;
	} stack_result_t;

	typedef struct {
		bit                 is_cfg;
		bss_pkg::opcode_t   op;
		logic signed [31:0] arg;
		logic signed [31:0] key;
		bit                 typed;
		bss_pkg::status_t   st;
		logic signed [31:0] dat;
	} plan_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [bss_pkg::CAP_W-1:0] cfg_wdata;

	bss_cmd_if cmd_ch();
	bss_res_if res_ch();

	bounded_stack_with_search_unit #(
		.DEPTH(DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow stack
	logic signed [31:0]        stack_mem [DEPTH];
	int                        live_count;
	logic [bss_pkg::CAP_W-1:0] cap_reg;

	stack_result_t op_results[$];
	stack_result_t awaited_results[$];
	plan_row_t     plan_rows[$];

	int  errors;
	int  cycles;
	int  rx_hold;
	bit  tx_quiet;
	bit  rx_quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** bounded_stack_with_search_unit: FAILED **");
			$finish;
		end
	end

	function automatic void add_result(bss_pkg::status_t st, logic signed [31:0] dat, int pos,
		bit occ, bit lst);
		stack_result_t r;
		r.status   = st;
		r.data     = dat;
		r.position = pos[6:0];
		r.occupied = occ;
		r.last     = lst;
		op_results.push_back(r);
	endfunction

	function automatic void apply_stack_op(bss_pkg::opcode_t op, logic signed [31:0] pv,
		logic signed [31:0] key);
		int lim;
		int hits;
		int seen;
		if (cap_reg == 0)
			lim = 1;
		else if (cap_reg > DEPTH)
			lim = DEPTH;
		else
			lim = cap_reg;
		op_results.delete();
		case (op)
			bss_pkg::OP_PUSH: begin
				if (live_count >= lim) begin
					add_result(bss_pkg::ST_FULL, 0, 0, 0, 1);
				end else begin
					stack_mem[live_count] = pv;
					live_count++;
					add_result(bss_pkg::ST_PUSHED, 0, 0, 0, 1);
				end
			end
			bss_pkg::OP_POP: begin
				if (live_count == 0) begin
					add_result(bss_pkg::ST_EMPTY, 0, 0, 0, 1);
				end else begin
					live_count--;
					add_result(bss_pkg::ST_POPPED, stack_mem[live_count], 0, 0, 1);
				end
			end
			bss_pkg::OP_SEARCH: begin
				hits = 0;
				seen = 0;
				for (int i = 0; i < live_count; i++)
					if (stack_mem[i] == key)
						hits++;
				if (live_count == 0) begin
					add_result(bss_pkg::ST_EMPTY, 0, 0, 0, 1);
				end else if (hits == 0) begin
					add_result(bss_pkg::ST_NOTFOUND, 0, 0, 0, 1);
				end else begin
					for (int i = 0; i < live_count; i++) begin
						if (stack_mem[i] == key) begin
							seen++;
							add_result(bss_pkg::ST_FOUND, 0, i + 1, 0, seen == hits);
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < lim; i++)
					add_result(bss_pkg::ST_FOUND,
						(i < live_count) ? stack_mem[i] : 32'sd0, i + 1,
						i < live_count, i == lim - 1);
			end
		endcase
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7) - 4;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	// result side: random stalls, compare against oldest expectation
	always @(posedge clk) begin
		stack_result_t want;
		if (!arst_n) begin
			rx_hold = 0;
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: st=%0d data=%h pos=%0d occ=%b last=%b",
							res_ch.status, res_ch.data, res_ch.position, res_ch.occupied,
							res_ch.last);
				end else begin
					want = awaited_results.pop_front();
					if (res_ch.status !== want.status || res_ch.data !== want.data ||
						res_ch.position !== want.position ||
						res_ch.occupied !== want.occupied || res_ch.last !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d %h %0d %b %b, got %0d %h %0d %b %b",
								want.status, want.data, want.position, want.occupied,
								want.last, res_ch.status, res_ch.data, res_ch.position,
								res_ch.occupied, res_ch.last);
					end
				end
				rx_hold = rx_quiet ? 0 : $urandom_range(0, 18);
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			res_ch.ready <= (rx_hold == 0);
		end
	end

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cap(logic [bss_pkg::CAP_W-1:0] value);
		drain_results();
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cap_reg = value;
	endtask

	task automatic send_word(bss_pkg::opcode_t op, logic signed [31:0] pv,
		logic signed [31:0] key, bit typed, bss_pkg::status_t st, logic signed [31:0] dat);
		int gap;
		stack_result_t r;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.opcode     <= op;
		cmd_ch.push_value <= pv;
		cmd_ch.search_key <= key;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		apply_stack_op(op, pv, key);
		if (typed) begin
			r.status   = st;
			r.data     = dat;
			r.position = 0;
			r.occupied = 0;
			r.last     = 1;
			awaited_results.push_back(r);
		end else begin
			foreach (op_results[i])
				awaited_results.push_back(op_results[i]);
		end
	endtask

	task automatic add_row(bit is_cfg, bss_pkg::opcode_t op, logic signed [31:0] arg,
		logic signed [31:0] key, bit typed, bss_pkg::status_t st, logic signed [31:0] dat);
		plan_row_t row;
		row.is_cfg = is_cfg;
		row.op     = op;
		row.arg    = arg;
		row.key    = key;
		row.typed  = typed;
		row.st     = st;
		row.dat    = dat;
		plan_rows.push_back(row);
	endtask

	initial begin
		int                        sent;
		int                        phase;
		int                        phase_len;
		int                        push_w;
		int                        r;
		bss_pkg::opcode_t          op;
		logic signed [31:0]        pv;
		logic signed [31:0]        key;
		logic [bss_pkg::CAP_W-1:0] cap_menu [8];

		cap_menu = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd5, 7'd64};
		tx_quiet   = 1'b0;
		rx_quiet   = 1'b0;
		live_count = 0;
		cap_reg    = bss_pkg::CAP_RESET;
		foreach (stack_mem[i])
			stack_mem[i] = 0;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.opcode     = '0;
		cmd_ch.push_value = '0;
		cmd_ch.search_key = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		add_row(0, bss_pkg::OP_POP,    0, 0, 1, bss_pkg::ST_EMPTY, 0);
		add_row(0, bss_pkg::OP_SEARCH, 0, 0, 1, bss_pkg::ST_EMPTY, 0);
		add_row(0, bss_pkg::OP_DUMP,   0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_PUSH,   32'sh7fffffff, 0, 1, bss_pkg::ST_PUSHED, 0);
		add_row(0, bss_pkg::OP_PUSH,   32'sh80000000, 0, 1, bss_pkg::ST_PUSHED, 0);
		add_row(0, bss_pkg::OP_PUSH,   32'shffffffff, 0, 1, bss_pkg::ST_PUSHED, 0);
		add_row(0, bss_pkg::OP_PUSH,   0, 0, 1, bss_pkg::ST_PUSHED, 0);
		add_row(0, bss_pkg::OP_PUSH,   32'sh80000000, 0, 1, bss_pkg::ST_PUSHED, 0);
		add_row(0, bss_pkg::OP_SEARCH, 0, 32'sh80000000, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_SEARCH, 0, 32'sh12345678, 1, bss_pkg::ST_NOTFOUND, 0);
		add_row(0, bss_pkg::OP_POP,    0, 0, 1, bss_pkg::ST_POPPED, 32'sh80000000);
		add_row(0, bss_pkg::OP_DUMP,   0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(1, bss_pkg::OP_PUSH,   0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_PUSH,   1, 0, 1, bss_pkg::ST_FULL, 0);
		add_row(0, bss_pkg::OP_DUMP,   0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_SEARCH, 0, 32'shffffffff, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_POP,    0, 0, 1, bss_pkg::ST_POPPED, 0);
		add_row(1, bss_pkg::OP_PUSH,   127, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_PUSH,   5, 32'shffffffff, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_DUMP,   0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(1, bss_pkg::OP_PUSH,   2, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_POP,    0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_POP,    0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_POP,    0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_POP,    0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(0, bss_pkg::OP_POP,    0, 0, 1, bss_pkg::ST_EMPTY, 0);
		add_row(0, bss_pkg::OP_DUMP,   0, 0, 0, bss_pkg::ST_FOUND, 0);
		add_row(1, bss_pkg::OP_PUSH,   64, 0, 0, bss_pkg::ST_FOUND, 0);

		foreach (plan_rows[i]) begin
			if (plan_rows[i].is_cfg)
				write_cap(plan_rows[i].arg[bss_pkg::CAP_W-1:0]);
			else
				send_word(plan_rows[i].op, plan_rows[i].arg, plan_rows[i].key,
					plan_rows[i].typed, plan_rows[i].st, plan_rows[i].dat);
		end

		// random part, one capacity per phase
		sent  = 0;
		phase = 0;
		while (sent < RAND_WORDS) begin
			write_cap(phase < 8 ? cap_menu[phase] :
				bss_pkg::CAP_W'($urandom_range(0, 127)));
			tx_quiet <= ($urandom_range(0, 3) == 0);
			rx_quiet <= ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				push_w    = 95;
				phase_len = 100;
			end else begin
				push_w    = 40 + 20 * $urandom_range(0, 2);
				phase_len = $urandom_range(20, 60);
			end
			for (int n = 0; n < phase_len && sent < RAND_WORDS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					op = bss_pkg::OP_DUMP;
				else if (r < 22)
					op = bss_pkg::OP_SEARCH;
				else if ($urandom_range(0, 99) < push_w)
					op = bss_pkg::OP_PUSH;
				else
					op = bss_pkg::OP_POP;
				pv = pick_word();
				if (live_count > 0 && $urandom_range(0, 1))
					key = stack_mem[$urandom_range(0, live_count - 1)];
				else
					key = pick_word();
				if ($urandom_range(0, 49) == 0)
					drain_results();
				send_word(op, pv, key, 0, bss_pkg::ST_FOUND, 0);
				sent++;
			end
			phase++;
		end

		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && awaited_results.size() == 0)
			$display("** bounded_stack_with_search_unit: PASSED **");
		else
			$display("** bounded_stack_with_search_unit: FAILED **");
		$finish;
	end

endmodule
